// ===== rtl/core/frame_cycle_sequencer_macros.svh =====
// Assertion macros shared by the frame cycle sequencer RTL.
`ifndef FRAME_CYCLE_SEQUENCER_MACROS_SVH
`define FRAME_CYCLE_SEQUENCER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define FCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame cycle sequencer check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define FCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame cycle sequencer check failed");

`endif

// ===== rtl/core/fcs_pkg.sv =====
// Shared types, constants and microcode program of the frame cycle sequencer.
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

  // Table geometry
  localparam int MAX_FRAMES = 32;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int WORD_W     = 32;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 6;
  localparam int SEED_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd2;

  // Timing constants
  localparam logic [WORD_W-1:0] LAG_LIMIT  = 32'd250;
  localparam logic [WORD_W-1:0] SKIP_AHEAD = 32'd10;
  localparam logic [7:0]        LFSR_TAPS  = 8'hB8;

  // Step addresses of the program
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_WRITE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RESTART = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LAGCHK  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_LOOPCHK = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADVANCE = 4'd5;
  localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_TEST    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RAND    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_WAIT    = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ADD     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd11;
  localparam logic [STEP_W-1:0] STEP_SKIP    = 4'd12;
  localparam logic [STEP_W-1:0] STEP_LAST    = STEP_SKIP;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WRITE,
    OP_RESTART,
    OP_CLEAR,
    OP_ADVANCE,
    OP_LOAD,
    OP_RAND,
    OP_ADD,
    OP_EMIT,
    OP_SKIP
  } op_e;

  // Next-step conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_LAG,
    C_DONE,
    C_NORAND,
    C_HOLD_MOD,
    C_HOLD_OUT
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic              lag;
    logic              done;
    logic              no_rand;
    logic              mod_busy;
    logic              out_full;
  } flags_t;

  // Sequencer control toward the datapath
  typedef struct packed {
    op_e  op;
    logic fetch;
  } ctrl_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      STEP_FETCH:   w = '{op: OP_NOP,     cond: C_DISPATCH, target: STEP_FETCH};
      STEP_WRITE:   w = '{op: OP_WRITE,   cond: C_JUMP,     target: STEP_FETCH};
      STEP_RESTART: w = '{op: OP_RESTART, cond: C_JUMP,     target: STEP_FETCH};
      STEP_LAGCHK:  w = '{op: OP_CLEAR,   cond: C_LAG,      target: STEP_SKIP};
      STEP_LOOPCHK: w = '{op: OP_NOP,     cond: C_DONE,     target: STEP_EMIT};
      STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: C_NEXT,     target: STEP_FETCH};
      STEP_LOAD:    w = '{op: OP_LOAD,    cond: C_NEXT,     target: STEP_FETCH};
      STEP_TEST:    w = '{op: OP_NOP,     cond: C_NORAND,   target: STEP_ADD};
      STEP_RAND:    w = '{op: OP_RAND,    cond: C_NEXT,     target: STEP_FETCH};
      STEP_WAIT:    w = '{op: OP_NOP,     cond: C_HOLD_MOD, target: STEP_ADD};
      STEP_ADD:     w = '{op: OP_ADD,     cond: C_JUMP,     target: STEP_LOOPCHK};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: C_HOLD_OUT, target: STEP_FETCH};
      STEP_SKIP:    w = '{op: OP_SKIP,    cond: C_JUMP,     target: STEP_EMIT};
      default:      w = '{op: OP_NOP,     cond: C_JUMP,     target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fcs_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module fcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/fcs_mod.sv =====
// Bit-serial 8-bit remainder unit: one restoring step per cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_cycle_sequencer_macros.svh"

module fcs_mod (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] dividend_i,
  input  wire logic [7:0] divisor_i,
  output logic            busy_o,
  output logic      [7:0] rem_o
);

  import fcs_pkg::*;

  localparam int BITS  = 8;
  localparam int CNT_W = $clog2(BITS + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BITS-1:0]  dd_q, dd_d;
  logic [BITS-1:0]  dv_q, dv_d;
  logic [BITS-1:0]  r_q, r_d;
  logic [BITS:0]    trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial  = {r_q, dd_q[BITS-1]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dd_d   = dd_q;
    dv_d   = dv_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(BITS);
      dd_d   = dividend_i;
      dv_d   = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dv_q}) begin
        r_d = BITS'(trial - {1'b0, dv_q});
      end else begin
        r_d = trial[BITS-1:0];
      end
      dd_d  = {dd_q[BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk_i) begin
    dd_q <= dd_d;
    dv_q <= dv_d;
    r_q  <= r_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = r_q;

  `FCS_ASSERT_NOW(a_rem_below_divisor, $fell(busy_q) && dv_q != '0, r_q < dv_q)
  `FCS_ASSERT_NOW(a_count_idle, !busy_q && !start_i, cnt_d == cnt_q)
  `FCS_ASSERT_NEXT(a_start_sets_busy, start_i, busy_q)

endmodule

`default_nettype wire

// ===== rtl/core/fcs_useq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_cycle_sequencer_macros.svh"

module fcs_useq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fcs_pkg::flags_t flags_i,
  output fcs_pkg::ctrl_t       ctrl_o
);

  import fcs_pkg::*;

  logic [STEP_W-1:0] pc_q, pc_d;
  logic [STEP_W-1:0] pc_inc;
  ucode_t            uw;
  logic              tick_take;

  assign uw     = ucode_rom(pc_q);
  assign pc_inc = pc_q + STEP_W'(1);

  // Pick the next step
  always_comb begin
    case (uw.cond)
      C_NEXT:     pc_d = pc_inc;
      C_JUMP:     pc_d = uw.target;
      C_DISPATCH: begin
        if (flags_i.in_valid) begin
          case (flags_i.func)
            FUNC_WRITE:   pc_d = STEP_WRITE;
            FUNC_RESTART: pc_d = STEP_RESTART;
            FUNC_TICK:    pc_d = STEP_LAGCHK;
            default:      pc_d = STEP_FETCH;
          endcase
        end else begin
          pc_d = pc_q;
        end
      end
      C_LAG:      pc_d = flags_i.lag ? uw.target : pc_inc;
      C_DONE:     pc_d = flags_i.done ? uw.target : pc_inc;
      C_NORAND:   pc_d = flags_i.no_rand ? uw.target : pc_inc;
      C_HOLD_MOD: pc_d = flags_i.mod_busy ? pc_q : uw.target;
      C_HOLD_OUT: pc_d = flags_i.out_full ? pc_q : uw.target;
      default:    pc_d = STEP_FETCH;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op    = uw.op;
  assign ctrl_o.fetch = (pc_q == STEP_FETCH);

  // Tick word taken at the fetch step
  assign tick_take = (pc_q == STEP_FETCH) && flags_i.in_valid && (flags_i.func == FUNC_TICK);

  `FCS_ASSERT_NOW(a_pc_in_program, 1'b1, pc_q <= STEP_LAST)
  `FCS_ASSERT_NEXT(a_tick_checks_lag, tick_take, pc_q == STEP_LAGCHK)
  `FCS_ASSERT_NEXT(a_write_returns, pc_q == STEP_WRITE, pc_q == STEP_FETCH)

endmodule

`default_nettype wire

// ===== rtl/core/frame_cycle_sequencer.sv =====
// Top level of the frame cycle sequencer: ports, registers and datapath.
// Write and restart words run their own step and go back to fetch; they give no result.
// A tick checks the lag; per frame advanced it runs advance, load and test, plus a draw
// and a wait on the 8-step remainder unit for a random-range frame, then add; a lagging
// tick skips ahead. Results leave via the output register; one word is in work at a time.
// Async active-low reset clears frame, change time and start frame, sets count 2, seed 1, LFSR 1.
`timescale 1ns / 1ps
`default_nettype none

`include "frame_cycle_sequencer_macros.svh"

module frame_cycle_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [fcs_pkg::FUNC_W-1:0]      func_i,
  input  wire logic [fcs_pkg::WORD_W-1:0]      time_now_i,
  input  wire logic [fcs_pkg::FRAME_W-1:0]     entry_index_i,
  input  wire logic [fcs_pkg::WORD_W-1:0]      entry_word_i,
  // Output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [fcs_pkg::FRAME_W-1:0]     frame_index_o,
  output logic                                 skipped_o,
  // Configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import fcs_pkg::*;

  flags_t flags;
  ctrl_t  ctrl;

  // Configuration registers
  logic [COUNT_W-1:0] frame_count_q;
  logic [FRAME_W-1:0] start_frame_q;
  logic [SEED_W-1:0]  random_seed_q;

  // Block state
  logic [FRAME_W-1:0] cur_q, cur_d;
  logic [WORD_W-1:0]  nc_q, nc_d;
  logic [7:0]         lfsr_q, lfsr_d;
  logic               skip_q, skip_d;
  logic               stop_q, stop_d;

  // Word registers
  logic [WORD_W-1:0]  now_q, now_d;
  logic [FRAME_W-1:0] idx_q, idx_d;
  logic [WORD_W-1:0]  word_q, word_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [FRAME_W-1:0] out_frame_q, out_frame_d;
  logic               out_skip_q, out_skip_d;

  // Datapath nets
  logic               in_accept;
  logic               out_full;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] cur_inc;
  logic [FRAME_W-1:0] wrap_frame;
  logic               lag;
  logic               due;
  logic [WORD_W:0]    ahead_sum;
  logic               fixed_word;
  logic [7:0]         range_byte;
  logic               no_rand;
  logic [7:0]         lfsr_next;
  logic [16:0]        ticks_raw;
  logic [16:0]        ticks;
  logic [WORD_W:0]    nc_sum;
  logic               mod_busy;
  logic [7:0]         mod_rem;
  logic [WORD_W-1:0]  ram_rdata;

  assign in_accept = in_valid_i && ctrl.fetch;
  assign out_full  = out_valid_q && !out_ready_i;

  // Clamp the frame count and find the frame after the current one
  assign cnt_eff    = (frame_count_q > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES)
                                                             : frame_count_q;
  assign cur_inc    = COUNT_W'(cur_q) + COUNT_W'(1);
  assign wrap_frame = (cur_inc >= cnt_eff) ? '0 : cur_inc[FRAME_W-1:0];

  // Lag and catch-up tests
  assign lag       = ({1'b0, nc_q} + {1'b0, LAG_LIMIT}) < {1'b0, now_q};
  assign due       = (nc_q <= now_q);
  assign ahead_sum = {1'b0, now_q} + {1'b0, SKIP_AHEAD};

  // Decode the duration word
  assign fixed_word = (word_q[WORD_W-1:8] == '0);
  assign range_byte = word_q[15:8];
  assign no_rand    = fixed_word || (range_byte == 8'd0);
  assign lfsr_next  = {1'b0, lfsr_q[7:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 8'd0);

  always_comb begin
    if (fixed_word) begin
      ticks_raw = {9'd0, word_q[7:0]};
    end else if (range_byte != 8'd0) begin
      ticks_raw = {1'b0, word_q[31:16]} + {9'd0, mod_rem};
    end else begin
      ticks_raw = {1'b0, word_q[31:16]};
    end
  end

  assign ticks  = (ticks_raw == '0) ? 17'd1 : ticks_raw;
  assign nc_sum = {1'b0, nc_q} + {16'd0, ticks};

  // Status toward the sequencer
  assign flags.in_valid = in_valid_i;
  assign flags.func     = func_i;
  assign flags.lag      = lag;
  assign flags.done     = !due || stop_q;
  assign flags.no_rand  = no_rand;
  assign flags.mod_busy = mod_busy;
  assign flags.out_full = out_full;

  fcs_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  fcs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.op == OP_RAND),
    .dividend_i (lfsr_next),
    .divisor_i  (range_byte),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  fcs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ctrl.op == OP_WRITE),
    .waddr_i (idx_q),
    .wdata_i (word_q),
    .raddr_i (wrap_frame),
    .rdata_o (ram_rdata)
  );

  // Execute the operation of the current step
  always_comb begin
    cur_d       = cur_q;
    nc_d        = nc_q;
    lfsr_d      = lfsr_q;
    skip_d      = skip_q;
    stop_d      = stop_q;
    now_d       = now_q;
    idx_d       = idx_q;
    word_d      = word_q;
    out_frame_d = out_frame_q;
    out_skip_d  = out_skip_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (in_accept) begin
      now_d  = time_now_i;
      idx_d  = entry_index_i;
      word_d = entry_word_i;
    end

    case (ctrl.op)
      OP_RESTART: begin
        cur_d  = start_frame_q;
        nc_d   = now_q;
        lfsr_d = (random_seed_q == '0) ? 8'd1 : random_seed_q;
      end
      OP_CLEAR: begin
        skip_d = 1'b0;
        stop_d = 1'b0;
      end
      OP_ADVANCE: cur_d  = wrap_frame;
      OP_LOAD:    word_d = ram_rdata;
      OP_RAND:    lfsr_d = lfsr_next;
      OP_ADD: begin
        stop_d = nc_sum[WORD_W];
        nc_d   = nc_sum[WORD_W] ? '1 : nc_sum[WORD_W-1:0];
      end
      OP_SKIP: begin
        skip_d = 1'b1;
        nc_d   = ahead_sum[WORD_W] ? '1 : ahead_sum[WORD_W-1:0];
      end
      OP_EMIT: begin
        if (!out_full) begin
          out_valid_d = 1'b1;
          out_frame_d = cur_q;
          out_skip_d  = skip_q;
        end
      end
      default: ;
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_W'(2);
      start_frame_q <= '0;
      random_seed_q <= SEED_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_START_FRAME: start_frame_q <= cfg_data_i[FRAME_W-1:0];
        CFG_RANDOM_SEED: random_seed_q <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold block state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      nc_q        <= '0;
      lfsr_q      <= 8'd1;
      skip_q      <= 1'b0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      nc_q        <= nc_d;
      lfsr_q      <= lfsr_d;
      skip_q      <= skip_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    idx_q       <= idx_d;
    word_q      <= word_d;
    out_frame_q <= out_frame_d;
    out_skip_q  <= out_skip_d;
  end

  assign in_ready_o    = ctrl.fetch;
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign skipped_o     = out_skip_q;

  `FCS_ASSERT_NEXT(a_emit_fills_output, ctrl.op == OP_EMIT && !out_full, out_valid_q)
  `FCS_ASSERT_NEXT(a_skip_lands_ahead, ctrl.op == OP_SKIP, nc_q >= $past(now_q))
  `FCS_ASSERT_NEXT(a_advance_in_cycle, ctrl.op == OP_ADVANCE && cnt_eff != '0, COUNT_W'(cur_q) < $past(cnt_eff))
  `FCS_ASSERT_NOW(a_no_accept_in_work, !ctrl.fetch, !in_accept)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the frame cycle sequencer: predictor, scoreboard and drivers.
`timescale 1ns / 1ps

module tb_top;
  import fcs_pkg::*;

  localparam int                RANDOM_WORDS  = 1450;
  localparam int                SETTLE_CYCLES = 8;
  localparam logic [FUNC_W-1:0] FUNC_IGNORED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] FIXED_MAX     = 32'd255;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               skipped;
  } frame_result_t;

  // Timing model of the sequencer plus the queue of results it still owes
  class frame_timer_scoreboard;
    logic [WORD_W-1:0]  durations [MAX_FRAMES];
    int                 cur_frame;
    logic [WORD_W-1:0]  change_at;
    logic [7:0]         lfsr;
    logic [COUNT_W-1:0] frame_count;
    logic [FRAME_W-1:0] start_frame;
    logic [SEED_W-1:0]  seed;
    frame_result_t      pending [$];
    int                 errors;

    function new();
      foreach (durations[i]) durations[i] = '0;
      cur_frame   = 0;
      change_at   = '0;
      lfsr        = 8'd1;
      frame_count = 6'd2;
      start_frame = '0;
      seed        = 8'd1;
      errors      = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_COUNT: frame_count = data[COUNT_W-1:0];
        CFG_START_FRAME: start_frame = data[FRAME_W-1:0];
        CFG_RANDOM_SEED: seed = data[SEED_W-1:0];
        default: ;
      endcase
    endfunction

    // Galois step, taps x^8+x^6+x^5+x^4+1
    function logic [7:0] next_random();
      logic lsb;
      lsb  = lfsr[0];
      lfsr = lfsr >> 1;
      if (lsb) lfsr = lfsr ^ LFSR_TAPS;
      return lfsr;
    endfunction

    // Small words are fixed ticks; larger ones are min plus a random share of the range
    function logic [WORD_W-1:0] frame_ticks(logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] ticks;
      logic [7:0]        range;
      if (word <= FIXED_MAX) begin
        ticks = word;
      end else begin
        range = word[15:8];
        ticks = {16'd0, word[31:16]};
        if (range != 8'd0) ticks = ticks + 32'(next_random() % range);
      end
      return (ticks == '0) ? 32'd1 : ticks;
    endfunction

    function void note_word(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] now,
                            logic [FRAME_W-1:0] idx, logic [WORD_W-1:0] word);
      logic [WORD_W:0] sum;
      int              limit;
      frame_result_t   res;
      case (func)
        FUNC_WRITE: durations[idx] = word;
        FUNC_RESTART: begin
          cur_frame = int'(start_frame);
          change_at = now;
          lfsr      = (seed == '0) ? 8'd1 : seed;
        end
        FUNC_TICK: begin
          res.skipped = 1'b0;
          if ({1'b0, change_at} + {1'b0, LAG_LIMIT} < {1'b0, now}) begin
            // too far behind: jump ahead instead of catching up
            sum         = {1'b0, now} + {1'b0, SKIP_AHEAD};
            change_at   = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
            res.skipped = 1'b1;
          end else begin
            limit = (frame_count > MAX_FRAMES) ? MAX_FRAMES : int'(frame_count);
            while (change_at <= now) begin
              cur_frame++;
              if (cur_frame >= limit) cur_frame = 0;
              sum = {1'b0, change_at} + {1'b0, frame_ticks(durations[cur_frame])};
              if (sum[WORD_W]) begin
                change_at = '1;
                break;
              end
              change_at = sum[WORD_W-1:0];
            end
          end
          res.frame = cur_frame[FRAME_W-1:0];
          pending   = {pending, res};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [FRAME_W-1:0] frame, logic skipped);
      frame_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: frame %0d skipped %0b",
                 $time, frame, skipped);
        return;
      end
      want = pending.pop_front();
      if (frame !== want.frame) begin
        errors++;
        $display("%0t: frame_index mismatch: expected %0d, actual %0d",
                 $time, want.frame, frame);
      end
      if (skipped !== want.skipped) begin
        errors++;
        $display("%0t: skipped mismatch: expected %0b, actual %0b",
                 $time, want.skipped, skipped);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i;
  logic [WORD_W-1:0]     time_now_i;
  logic [FRAME_W-1:0]    entry_index_i;
  logic [WORD_W-1:0]     entry_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [FRAME_W-1:0]    frame_index_o;
  logic                  skipped_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frame_timer_scoreboard sb;
  bit  calm;
  bit  table_loaded [MAX_FRAMES];
  int  words_sent;
  int  ticks_sent;
  int  results_seen;
  int  skips_seen;
  int  settings_used;

  frame_cycle_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .time_now_i    (time_now_i),
    .entry_index_i (entry_index_i),
    .entry_word_i  (entry_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_index_o (frame_index_o),
    .skipped_o     (skipped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Drive one input word after a random gap; entered and left at a falling edge
  task automatic send_word(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] now,
                           logic [FRAME_W-1:0] idx, logic [WORD_W-1:0] word);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    func_i        = func;
    time_now_i    = now;
    entry_index_i = idx;
    entry_word_i  = word;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(func, now, idx, word);
    if (func != FUNC_IGNORED) words_sent++;
    if (func == FUNC_TICK) ticks_sent++;
    if (func == FUNC_WRITE) table_loaded[idx] = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold the input until every owed result is out, then let the block settle
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_duration();
    case ($urandom_range(0, 19))
      0, 1:          return 32'd0;
      2, 3, 4, 5, 6: return 32'($urandom_range(1, 12));
      7, 8:          return 32'($urandom_range(13, 255));
      9, 10, 11, 12, 13, 14:
        return {16'($urandom_range(0, 8)), 8'($urandom_range(0, 24)), 8'($urandom)};
      15, 16, 17, 18:
        return {16'($urandom_range(0, 8)), 8'($urandom), 8'($urandom)};
      default:       return 32'($urandom);
    endcase
  endfunction

  // Tick times mostly follow the predicted change time so the catch-up loop stays busy
  function automatic logic [WORD_W-1:0] pick_tick_time();
    logic [WORD_W-1:0] base;
    base = sb.change_at;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: return base + 32'($urandom_range(0, 24));
      11, 12, 13:                       return base - 32'($urandom_range(0, 40));
      14:     return base + LAG_LIMIT + 32'($urandom_range(0, 1));
      15:     return base + LAG_LIMIT + 32'($urandom_range(2, 1000));
      16, 17: return 32'($urandom);
      18:     return 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
      default: return base + 32'($urandom_range(25, 120));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_restart_time();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
      default: return 32'($urandom);
    endcase
  endfunction

  // Result side: random stall before each word, checked at the rising edge
  initial begin : result_sink
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(frame_index_o, skipped_o);
      results_seen++;
      if (skipped_o) skips_seen++;
    end
  end

  initial begin : stimulus
    logic [7:0]  count_plan [7];
    logic [7:0]  start_plan [7];
    logic [7:0]  seed_plan  [7];
    logic [7:0]  count_data;
    logic [7:0]  start_data;
    logic [7:0]  seed_data;
    int          phase;
    int          goal;
    int          eff;
    int          need;
    int          len;
    int          pick;

    count_plan    = '{8'd2, 8'd32, 8'd1, 8'd0, 8'd63, 8'd33, 8'd8};
    start_plan    = '{8'd0, 8'd31, 8'd0, 8'd5, 8'd31, 8'd17, 8'd20};
    seed_plan     = '{8'd1, 8'd255, 8'd0, 8'd128, 8'd1, 8'd0, 8'd77};
    sb            = new();
    calm          = 1'b0;
    words_sent    = 0;
    ticks_sent    = 0;
    results_seen  = 0;
    skips_seen    = 0;
    settings_used = 1;
    foreach (table_loaded[i]) table_loaded[i] = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_WRITE;
    time_now_i    = '0;
    entry_index_i = '0;
    entry_word_i  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FRAME_COUNT;
    cfg_data_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero duration and a unit random range on the two live frames
    send_word(FUNC_WRITE, '1, 5'd0, 32'd0);
    send_word(FUNC_WRITE, '0, 5'd1, 32'h0000_0100);
    send_word(FUNC_TICK, 32'd0, '1, '1);
    send_word(FUNC_TICK, 32'd5, '0, '0);
    // Minimum without a random range, then the widest random range
    send_word(FUNC_WRITE, 32'($urandom), 5'd1, 32'h0003_0000);
    send_word(FUNC_WRITE, 32'($urandom), 5'd0, 32'h00FF_FF00);
    send_word(FUNC_TICK, 32'd20, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'd20, 5'($urandom), 32'($urandom));
    // Lag right at the limit, then one tick past it
    send_word(FUNC_RESTART, 32'd100, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'd350, 5'($urandom), 32'($urandom));
    send_word(FUNC_RESTART, 32'd100, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'd351, 5'($urandom), 32'($urandom));
    // Catch-up that runs into the top of the time range
    send_word(FUNC_WRITE, 32'($urandom), 5'd0, 32'hFFFF_FF00);
    send_word(FUNC_RESTART, 32'hFFFF_FFF0, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'hFFFF_FFFF, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'hFFFF_FFFF, 5'($urandom), 32'($urandom));
    // Skip ahead past the top of the time range
    send_word(FUNC_RESTART, 32'd0, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'hFFFF_FFFF, 5'($urandom), 32'($urandom));
    send_word(FUNC_TICK, 32'hFFFF_FFFF, 5'($urandom), 32'($urandom));
    // Top table entry with all ones, and the unused function code
    send_word(FUNC_WRITE, 32'd0, 5'd31, 32'hFFFF_FFFF);
    send_word(FUNC_IGNORED, '1, '1, '1);
    drain_results();

    goal  = words_sent + RANDOM_WORDS;
    phase = 0;
    while (words_sent < goal) begin
      calm = ($urandom_range(0, 3) == 0);
      // Pick a register setting: the planned extremes first, random ones after
      if (phase < 7) begin
        count_data = count_plan[phase];
        start_data = start_plan[phase];
        seed_data  = seed_plan[phase];
      end else begin
        count_data = ($urandom_range(0, 1) != 0) ?
                     {2'($urandom), 6'($urandom_range(2, 12))} : 8'($urandom);
        start_data = 8'($urandom);
        seed_data  = 8'($urandom);
      end
      program_register(CFG_FRAME_COUNT, count_data);
      program_register(CFG_START_FRAME, start_data);
      program_register(CFG_RANDOM_SEED, seed_data);
      if ($urandom_range(0, 3) == 0) program_register(CFG_UNUSED, 8'($urandom));
      settings_used++;

      // Load every entry the cycle can reach before the first tick
      eff  = (count_data[5:0] > MAX_FRAMES) ? MAX_FRAMES : int'(count_data[5:0]);
      need = (eff < 2) ? 1 : eff;
      for (int i = 0; i < need; i++) begin
        if (!table_loaded[i] || $urandom_range(0, 1) != 0)
          send_word(FUNC_WRITE, 32'($urandom), 5'(i), pick_duration());
      end
      if ($urandom_range(0, 5) != 0)
        send_word(FUNC_RESTART, pick_restart_time(), 5'($urandom), 32'($urandom));

      len = $urandom_range(30, 70);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78)
          send_word(FUNC_TICK, pick_tick_time(), 5'($urandom), 32'($urandom));
        else if (pick < 88)
          send_word(FUNC_WRITE, 32'($urandom), 5'($urandom), pick_duration());
        else if (pick < 93)
          send_word(FUNC_RESTART, pick_restart_time(), 5'($urandom), 32'($urandom));
        else if (pick < 97)
          send_word(FUNC_IGNORED, 32'($urandom), 5'($urandom), 32'($urandom));
        else
          drain_results();
      end
      drain_results();
      phase++;
    end

    calm = 1'b0;
    drain_results();
    $display("covered %0d input words (%0d ticks) over %0d register settings",
             words_sent, ticks_sent, settings_used);
    $display("checked %0d results, %0d of them skipped ahead, %0d mismatches",
             results_seen, skips_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin : watchdog
    #250_000_000;
    $display("timeout with %0d results still owed", sb.pending.size());
    $display("status: fail");
    $finish;
  end

endmodule
